### rtl/moving_average_deadband_reporter_assert.svh
// Assertion macros for the moving average deadband reporter.
// No dependencies; included by the top level ahead of its assertions.
`ifndef MOVING_AVERAGE_DEADBAND_REPORTER_ASSERT_SVH
`define MOVING_AVERAGE_DEADBAND_REPORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MAD_ASSERT_NOW(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("mad assertion failed");
// next-cycle implication
`define MAD_ASSERT_NEXT(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("mad assertion failed");
`else
`define MAD_ASSERT_NOW(lbl, ant, cons)
`define MAD_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

### rtl/mad_pkg.sv
// Shared types and constants for the moving average deadband reporter.
// No dependencies; compiled first.
package mad_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int WINDOW_DEFAULT = 7;

   typedef logic [SAMPLE_W-1:0] sample_type;

   localparam sample_type THRESHOLD_RESET = sample_type'(100);

   // average handed from the mean pipeline to the deadband stage
   typedef struct packed {
      logic       valid;
      sample_type avg;
   } avg_stage_type;

endpackage

### rtl/mad_req_if.sv
// Sample channel: valid/ready handshake carrying one converter sample.
// Depends on mad_pkg.
interface mad_req_if;
   logic               valid;
   logic               ready;
   mad_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### rtl/mad_rsp_if.sv
// Report channel: valid/ready handshake carrying one reported average.
// Depends on mad_pkg.
interface mad_rsp_if;
   logic               valid;
   logic               ready;
   mad_pkg::sample_type reported_average;

   modport source (output valid, output reported_average, input ready);
   modport sink   (input valid, input reported_average, output ready);
endinterface

### rtl/mad_cell.sv
// One window cell: holds a sample and passes it to its neighbor on shift.
// Depends on mad_pkg.
module mad_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  mad_pkg::sample_type upstream,
   output mad_pkg::sample_type held
);
   import mad_pkg::*;

   sample_type held_ff;
   sample_type held_in;

   assign held_in = shift_en ? upstream : held_ff;
   assign held    = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

### rtl/mad_mean.sv
// Running sum and divide-by-window pipeline (reciprocal multiply).
// Depends on mad_pkg.
module mad_mean #(
   parameter int WINDOW = mad_pkg::WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  mad_pkg::sample_type    fresh,
   input  mad_pkg::sample_type    oldest,
   output logic                   in_ready,
   output mad_pkg::avg_stage_type avg_out,
   input  logic                   avg_ready
);
   import mad_pkg::*;

   localparam int L      = $clog2(WINDOW);
   localparam int SUM_W  = SAMPLE_W + L;
   localparam int SHIFT  = SUM_W + L;
   localparam int MULT_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + MULT_W;
   // ceil(2^SHIFT / WINDOW): exact floor quotient for any SUM_W-bit sum
   localparam int unsigned RECIP_I = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
   localparam logic [MULT_W-1:0] RECIP = RECIP_I[MULT_W-1:0];

   logic              sum_valid_ff, sum_valid_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic              prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0] product_ff, product_in;
   logic              sum_adv;

   assign in_ready = !sum_valid_ff || !prod_valid_ff || avg_ready;
   assign sum_adv  = sum_valid_ff && (!prod_valid_ff || avg_ready);

   always_comb begin
      running_sum_in = running_sum_ff;
      if (accept) begin
         running_sum_in = running_sum_ff - SUM_W'(oldest) + SUM_W'(fresh);
      end
   end

   assign sum_valid_in  = accept || (sum_valid_ff && !sum_adv);
   assign prod_valid_in = sum_adv || (prod_valid_ff && !avg_ready);
   assign product_in    = sum_adv ? PROD_W'(running_sum_ff) * PROD_W'(RECIP) : product_ff;

   assign avg_out.valid = prod_valid_ff;
   assign avg_out.avg   = product_ff[SHIFT +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff   <= 1'b0;
         running_sum_ff <= '0;
         prod_valid_ff  <= 1'b0;
      end else begin
         sum_valid_ff   <= sum_valid_in;
         running_sum_ff <= running_sum_in;
         prod_valid_ff  <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### rtl/mad_deadband.sv
// Send-on-delta decision, threshold register and report output register.
// Depends on mad_pkg.
module mad_deadband (
   input  logic                   clock,
   input  logic                   reset,
   input  mad_pkg::avg_stage_type avg_in,
   output logic                   avg_ready,
   input  logic                   csr_write,
   input  mad_pkg::sample_type    csr_value,
   output logic                   rsp_valid,
   output mad_pkg::sample_type    rsp_value,
   input  logic                   rsp_ready
);
   import mad_pkg::*;

   sample_type threshold_ff, threshold_in;
   sample_type last_ff, last_in;
   logic       has_reported_ff, has_reported_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_value_ff, rsp_value_in;
   sample_type diff;
   logic       fire;

   assign avg_ready = !rsp_valid_ff || rsp_ready;

   assign diff = (avg_in.avg >= last_ff) ? (avg_in.avg - last_ff) : (last_ff - avg_in.avg);
   assign fire = avg_in.valid && avg_ready && (!has_reported_ff || (diff > threshold_ff));

   assign threshold_in    = csr_write ? csr_value : threshold_ff;
   assign last_in         = fire ? avg_in.avg : last_ff;
   assign has_reported_in = has_reported_ff || fire;
   assign rsp_valid_in    = fire || (rsp_valid_ff && !rsp_ready);
   assign rsp_value_in    = fire ? avg_in.avg : rsp_value_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         last_ff         <= '0;
         has_reported_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         threshold_ff    <= threshold_in;
         last_ff         <= last_in;
         has_reported_ff <= has_reported_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

endmodule

### rtl/moving_average_deadband_reporter.sv
// Top level of the moving average deadband reporter.
// Depends on mad_pkg, mad_req_if, mad_rsp_if, mad_cell, mad_mean, mad_deadband
// and the assertion header.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   req_if   | in        | valid / ready          | sample, 12 bit
//   rsp_if   | out       | valid / ready          | reported_average, 12 bit
//   csr_     | in        | csr_valid / csr_ready  | csr_data, change threshold
//
// Throughput: one sample transaction per cycle while rsp_ready is high; the
// running-sum update and the compare/update of the last reported value set it.
// A report appears on rsp_if after its sample passes the sum register, the
// reciprocal product register and the output register.
// Reset: synchronous; window cells, sum and history clear at once.
// Stalls: rsp_ready low backs up through the product and sum stages; req_ready
// drops only when all three slots are full and the output is not taken.
`include "moving_average_deadband_reporter_assert.svh"

module moving_average_deadband_reporter #(
   parameter int WINDOW = mad_pkg::WINDOW_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   mad_req_if.sink             req_if,
   mad_rsp_if.source           rsp_if,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  mad_pkg::sample_type csr_data
);
   import mad_pkg::*;

   logic          accept;
   logic          mean_ready;
   logic          db_ready;
   avg_stage_type avg_stage;

   // chain[0] is the incoming sample, chain[WINDOW] the one leaving the window
   sample_type chain [WINDOW+1];

   // the threshold register takes a write in any cycle
   assign csr_ready = 1'b1;

   assign req_if.ready = mean_ready;
   assign accept       = req_if.valid && mean_ready;
   assign chain[0]     = req_if.sample;

   // Window as a shift line: every accepted sample moves each cell one step,
   // so the last cell always holds the sample that the new one displaces.
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      mad_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .upstream (chain[i]),
         .held     (chain[i+1])
      );
   end

   mad_mean #(
      .WINDOW (WINDOW)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .fresh     (req_if.sample),
      .oldest    (chain[WINDOW]),
      .in_ready  (mean_ready),
      .avg_out   (avg_stage),
      .avg_ready (db_ready)
   );

   mad_deadband u_deadband (
      .clock     (clock),
      .reset     (reset),
      .avg_in    (avg_stage),
      .avg_ready (db_ready),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .rsp_valid (rsp_if.valid),
      .rsp_value (rsp_if.reported_average),
      .rsp_ready (rsp_if.ready)
   );

   // a waiting report blocks the decision stage
   `MAD_ASSERT_NOW(a_db_blocked, rsp_if.valid && !rsp_if.ready, !db_ready)
   // a stalled average holds its value
   `MAD_ASSERT_NEXT(a_avg_hold, avg_stage.valid && !db_ready, avg_stage.valid && $stable(avg_stage.avg))
   // output empties once taken with nothing behind it
   `MAD_ASSERT_NEXT(a_rsp_drain, rsp_if.valid && rsp_if.ready && !avg_stage.valid, !rsp_if.valid)

endmodule
